>>> sv/xtppi_pkg.sv
package xtppi_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_CODE  = 2'd2,
    KIND_TICK  = 2'd3
  } kind_e;

  // Bus port select
  typedef enum logic [1:0] {
    ADDR_PORT_A  = 2'd0,
    ADDR_PORT_B  = 2'd1,
    ADDR_PORT_C  = 2'd2,
    ADDR_CONTROL = 2'd3
  } addr_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_SWITCH_LOW_NIBBLE = 2'd0;
  localparam logic [1:0] CFG_SWITCH_BIT_FIVE   = 2'd1;
  localparam logic [1:0] CFG_SYSREQ_ENABLE     = 2'd2;

  // Direction bit positions (1 means input)
  localparam int unsigned DIR_A  = 0;
  localparam int unsigned DIR_B  = 1;
  localparam int unsigned DIR_CU = 2;
  localparam int unsigned DIR_CL = 3;

  localparam logic [7:0] CODE_BREAK_PREFIX = 8'hF0;
  localparam logic [7:0] RAW_SYSREQ_ARM    = 8'h84;
  localparam logic [7:0] RAW_SYSREQ_FIRE   = 8'h11;
  localparam logic [7:0] BREAK_BIT         = 8'h80;
  localparam logic [7:0] CONTROL_READBACK  = 8'hFF;
  localparam logic [1:0] IRQ_COUNT_MAX     = 2'd3;

  typedef struct packed {
    kind_e      kind;
    addr_e      address;
    logic [7:0] write_data;
    logic [7:0] raw_code;
    logic [7:0] converted_code;
    logic       irq_taken;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       code_accepted;
    logic       irq_request;
    logic       sysreq_pulse;
  } out_item_t;

endpackage

>>> sv/xt_ppi_ports_and_keyboard_latch.sv
// PC/XT parallel port block (8255-style, mode 0 only) with a keyboard byte
// latch. Each input beat is a bus read, a bus write, a keyboard code offer
// (already converted to set 1) or an interrupt tick, and yields exactly one
// result beat. All work is done in one pass of logic between the state
// registers and the result register: a beat is taken every cycle while
// in_stall_o is low. The result side has a two-deep buffer (result
// register plus skid register), so a new beat is still taken while one
// finished result waits under stall; in_stall_o rises only when both are
// full. The configuration port (switch bits and system request enable)
// never stalls and must only be written while the block is idle.
module xt_ppi_ports_and_keyboard_latch (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xtppi_pkg::in_item_t in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xtppi_pkg::out_item_t out_data_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [3:0]          cfg_data_i
);

  // Configuration registers
  logic [3:0] sw_low_q;
  logic       sw_bit5_q;
  logic       sysreq_en_q;

  // Port and keyboard state
  logic [7:0] latch_a_q, latch_a_d;
  logic [7:0] latch_b_q, latch_b_d;
  logic [7:0] latch_c_q, latch_c_d;
  logic [3:0] dir_q, dir_d;
  logic [7:0] key_byte_q, key_byte_d;
  logic       key_full_q, key_full_d;
  logic       break_q, break_d;
  logic [1:0] irq_cnt_q, irq_cnt_d;
  logic       armed_q, armed_d;

  // Result buffering
  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  xtppi_pkg::out_item_t out_q, out_d;
  xtppi_pkg::out_item_t skid_q, skid_d;

  xtppi_pkg::out_item_t res;
  logic                 in_accept;
  logic                 out_fire;
  logic [7:0]           port_c_rd;
  logic [7:0]           c_mask;
  logic [7:0]           c_bit;
  logic [7:0]           key_val;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Port C read view: input halves float high, then the switch bits
  // selected by PB2 are mixed in.
  always_comb begin
    port_c_rd[7:4] = dir_q[xtppi_pkg::DIR_CU] ? 4'hF : latch_c_q[7:4];
    port_c_rd[3:0] = dir_q[xtppi_pkg::DIR_CL] ? 4'hF : latch_c_q[3:0];
    if (latch_b_q[2]) begin
      port_c_rd[3:0] = sw_low_q;
    end else begin
      port_c_rd[0] = sw_bit5_q;
    end
  end

  // Writable half-bytes of port C and the single-bit mask of a bit set/reset
  assign c_mask = {{4{!dir_q[xtppi_pkg::DIR_CU]}}, {4{!dir_q[xtppi_pkg::DIR_CL]}}};
  assign c_bit  = 8'd1 << in_data_i.write_data[3:1];
  // A code after the break prefix is latched as a release code
  assign key_val = break_q ? (in_data_i.converted_code | xtppi_pkg::BREAK_BIT)
                           : in_data_i.converted_code;

  // Single-pass update for the beat on the input channel
  always_comb begin
    latch_a_d  = latch_a_q;
    latch_b_d  = latch_b_q;
    latch_c_d  = latch_c_q;
    dir_d      = dir_q;
    key_byte_d = key_byte_q;
    key_full_d = key_full_q;
    break_d    = break_q;
    irq_cnt_d  = irq_cnt_q;
    armed_d    = armed_q;
    res        = '0;

    unique case (in_data_i.kind)
      xtppi_pkg::KIND_READ: begin
        unique case (in_data_i.address)
          xtppi_pkg::ADDR_PORT_A: begin
            if (dir_q[xtppi_pkg::DIR_A]) begin
              res.read_data = key_full_q ? key_byte_q : 8'h00;
            end else begin
              res.read_data = latch_a_q;
            end
          end
          xtppi_pkg::ADDR_PORT_B:  res.read_data = latch_b_q;
          xtppi_pkg::ADDR_PORT_C:  res.read_data = port_c_rd;
          xtppi_pkg::ADDR_CONTROL: res.read_data = xtppi_pkg::CONTROL_READBACK;
          default:                 res.read_data = 8'h00;
        endcase
      end
      xtppi_pkg::KIND_WRITE: begin
        unique case (in_data_i.address)
          xtppi_pkg::ADDR_PORT_A: begin
            if (!dir_q[xtppi_pkg::DIR_A]) begin
              latch_a_d = in_data_i.write_data;
            end
          end
          xtppi_pkg::ADDR_PORT_B: begin
            latch_b_d = in_data_i.write_data;
            // PB7 rising edge acknowledges the key byte
            if (!latch_b_q[7] && in_data_i.write_data[7]) begin
              key_full_d = 1'b0;
              irq_cnt_d  = 2'd0;
            end
          end
          xtppi_pkg::ADDR_PORT_C: begin
            latch_c_d = (latch_c_q & ~c_mask) | (in_data_i.write_data & c_mask);
          end
          xtppi_pkg::ADDR_CONTROL: begin
            if (in_data_i.write_data[7]) begin
              dir_d[xtppi_pkg::DIR_A]  = in_data_i.write_data[4];
              dir_d[xtppi_pkg::DIR_B]  = in_data_i.write_data[1];
              dir_d[xtppi_pkg::DIR_CU] = in_data_i.write_data[3];
              dir_d[xtppi_pkg::DIR_CL] = in_data_i.write_data[0];
            end else if (in_data_i.write_data[0]) begin
              latch_c_d = latch_c_q | c_bit;
            end else begin
              latch_c_d = latch_c_q & ~c_bit;
            end
          end
          default: ;
        endcase
      end
      xtppi_pkg::KIND_CODE: begin
        if (!key_full_q) begin
          res.code_accepted = 1'b1;
          // System request: break of 84h arms, break of 11h fires
          if (sysreq_en_q && break_q) begin
            if (in_data_i.raw_code == xtppi_pkg::RAW_SYSREQ_ARM) begin
              armed_d = 1'b1;
            end else if (armed_q && in_data_i.raw_code == xtppi_pkg::RAW_SYSREQ_FIRE) begin
              armed_d          = 1'b0;
              res.sysreq_pulse = 1'b1;
            end
          end
          if (in_data_i.converted_code == xtppi_pkg::CODE_BREAK_PREFIX) begin
            break_d = 1'b1;
          end else begin
            break_d    = 1'b0;
            key_byte_d = key_val;
            key_full_d = 1'b1;
            if (irq_cnt_q != xtppi_pkg::IRQ_COUNT_MAX) begin
              irq_cnt_d = irq_cnt_q + 2'd1;
            end
          end
        end
      end
      xtppi_pkg::KIND_TICK: begin
        if (irq_cnt_q != 2'd0) begin
          res.irq_request = 1'b1;
          if (in_data_i.irq_taken) begin
            irq_cnt_d = irq_cnt_q - 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result register plus skid: drain skid first, else place the new beat
  // in whichever slot is free.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_fire) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_low_q     <= 4'd0;
      sw_bit5_q    <= 1'b0;
      sysreq_en_q  <= 1'b0;
      latch_a_q    <= 8'd0;
      latch_b_q    <= 8'd0;
      latch_c_q    <= 8'd0;
      dir_q        <= 4'hF;
      key_byte_q   <= 8'd0;
      key_full_q   <= 1'b0;
      break_q      <= 1'b0;
      irq_cnt_q    <= 2'd0;
      armed_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == xtppi_pkg::CFG_SWITCH_LOW_NIBBLE) begin
          sw_low_q <= cfg_data_i;
        end else if (cfg_index_i == xtppi_pkg::CFG_SWITCH_BIT_FIVE) begin
          sw_bit5_q <= cfg_data_i[0];
        end else if (cfg_index_i == xtppi_pkg::CFG_SYSREQ_ENABLE) begin
          sysreq_en_q <= cfg_data_i[0];
        end
      end
      if (in_accept) begin
        latch_a_q  <= latch_a_d;
        latch_b_q  <= latch_b_d;
        latch_c_q  <= latch_c_d;
        dir_q      <= dir_d;
        key_byte_q <= key_byte_d;
        key_full_q <= key_full_d;
        break_q    <= break_d;
        irq_cnt_q  <= irq_cnt_d;
        armed_q    <= armed_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // A held skid beat always sits behind a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while the result register is empty");

  // Skid beat moves up once the result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid beat not advanced after result was taken");

  // Pending interrupts only exist while a key byte is latched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (irq_cnt_q != 2'd0) |-> key_full_q)
    else $error("interrupt pending with empty key latch");

  // A non-prefix code taken into an empty latch fills it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.kind == xtppi_pkg::KIND_CODE && !key_full_q &&
     in_data_i.converted_code != xtppi_pkg::CODE_BREAK_PREFIX) |=> key_full_q)
    else $error("accepted key code did not fill the latch");

endmodule
